@@ rtl/core/i2c_master_bit_sequencer_assert.svh @@
// Assertion macros used by the checker module of the I2C bit sequencer.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cm assertion failed");

`endif

@@ rtl/core/i2cm_pkg.sv @@
package i2cm_pkg;

   localparam int BITS_PER_BYTE = 8;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // Phase numbers are 1-based; these are the last phase of each sequence.
   localparam logic [5:0] SHORT_LAST_STEP = 6'd4;
   localparam logic [5:0] WRITE_LAST_STEP = 6'(3 * BITS_PER_BYTE + 2);
   localparam logic [5:0] READ_LAST_STEP  = 6'(2 * BITS_PER_BYTE + 3);

   // Zero-based phase offsets inside the write and read sequences.
   localparam logic [4:0] WR_ACK_LOW_PHASE = 5'(3 * BITS_PER_BYTE);
   localparam logic [4:0] RD_ACK_LOW_PHASE = 5'(2 * BITS_PER_BYTE);
   localparam logic [4:0] RD_ACK_SDA_PHASE = 5'(2 * BITS_PER_BYTE + 1);

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd4;

   typedef struct packed {
      logic       cmd_valid;
      cmd_type    command;
      logic [7:0] write_byte;
      logic       ack_to_send;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_received;
   } rsp_word_type;

endpackage

@@ rtl/core/i2cm_stream_if.sv @@
interface i2cm_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/i2cm_seq_core.sv @@
module i2cm_seq_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  i2cm_pkg::req_word_type req_word,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   output i2cm_pkg::rsp_word_type rsp_word
);

   logic [15:0]       phase_ticks_ff;
   logic [15:0]       tick_ff, tick_in;
   logic [5:0]        step_ff, step_in;
   logic [7:0]        shift_ff, shift_in;
   i2cm_pkg::cmd_type cmd_ff, cmd_in;
   logic              scl_lvl_ff, scl_lvl_in;
   logic              sda_lvl_ff, sda_lvl_in;
   logic              ack_reg_ff, ack_reg_in;
   logic              pend_ff, pend_in;
   logic [7:0]        rdata_ff, rdata_in;

   logic [15:0] hold;
   logic [15:0] tick_dec;
   logic [5:0]  last_step;
   logic        do_phase;
   logic        done;
   logic [4:0]  phase;
   logic [8:0]  div_prod;
   logic [2:0]  wr_bit;
   logic [4:0]  wr_rem;
   logic [7:0]  shift_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         step_ff    <= '0;
         shift_ff   <= '0;
         cmd_ff     <= i2cm_pkg::CMD_START;
         scl_lvl_ff <= 1'b1;
         sda_lvl_ff <= 1'b1;
         ack_reg_ff <= 1'b0;
         pend_ff    <= 1'b0;
         rdata_ff   <= '0;
      end else if (accept) begin
         tick_ff    <= tick_in;
         step_ff    <= step_in;
         shift_ff   <= shift_out;
         cmd_ff     <= cmd_in;
         scl_lvl_ff <= scl_lvl_in;
         sda_lvl_ff <= sda_lvl_in;
         ack_reg_ff <= ack_reg_in;
         pend_ff    <= pend_in;
         rdata_ff   <= rdata_in;
      end
   end

   always_comb begin
      unique case (cmd_ff)
         i2cm_pkg::CMD_WRITE: last_step = i2cm_pkg::WRITE_LAST_STEP;
         i2cm_pkg::CMD_READ:  last_step = i2cm_pkg::READ_LAST_STEP;
         default:             last_step = i2cm_pkg::SHORT_LAST_STEP;
      endcase
   end

   // Sequence control: start a command when idle, else count down the phase and advance or finish.
   always_comb begin
      hold       = (phase_ticks_ff == '0) ? 16'd1 : phase_ticks_ff;
      tick_dec   = (tick_ff != '0) ? tick_ff - 16'd1 : tick_ff;
      tick_in    = tick_ff;
      step_in    = step_ff;
      shift_in   = shift_ff;
      cmd_in     = cmd_ff;
      pend_in    = pend_ff;
      rdata_in   = rdata_ff;
      do_phase   = 1'b0;
      done       = 1'b0;
      if (step_ff == '0) begin
         if (req_word.cmd_valid) begin
            cmd_in = req_word.command;
            if (req_word.command == i2cm_pkg::CMD_WRITE) begin
               shift_in = req_word.write_byte;
            end
            if (req_word.command == i2cm_pkg::CMD_READ) begin
               shift_in = '0;
               pend_in  = req_word.ack_to_send;
            end
            step_in  = 6'd1;
            tick_in  = hold;
            do_phase = 1'b1;
         end
      end else begin
         tick_in = tick_dec;
         if (tick_dec == '0) begin
            if (step_ff >= last_step) begin
               if (cmd_ff == i2cm_pkg::CMD_READ) begin
                  rdata_in = shift_ff;
               end
               step_in = '0;
               done    = 1'b1;
            end else begin
               step_in  = step_ff + 6'd1;
               tick_in  = hold;
               do_phase = 1'b1;
            end
         end
      end
   end

   // Pin action of the phase being entered. Bit number of a write phase is
   // phase / 3, done as a multiply by 11 and a shift for phases below 24.
   always_comb begin
      phase      = 5'(step_in - 6'd1);
      div_prod   = 9'(phase) * 9'd11;
      wr_bit     = div_prod[7:5];
      wr_rem     = phase - {1'b0, wr_bit, 1'b0} - {2'b00, wr_bit};
      scl_lvl_in = scl_lvl_ff;
      sda_lvl_in = sda_lvl_ff;
      ack_reg_in = ack_reg_ff;
      if (do_phase) begin
         unique case (cmd_in)
            i2cm_pkg::CMD_START: begin
               priority if (phase == 5'd0) scl_lvl_in = 1'b0;
               else if (phase == 5'd1)     sda_lvl_in = 1'b1;
               else if (phase == 5'd2)     scl_lvl_in = 1'b1;
               else                        sda_lvl_in = 1'b0;
            end
            i2cm_pkg::CMD_STOP: begin
               priority if (phase == 5'd0) scl_lvl_in = 1'b0;
               else if (phase == 5'd1)     sda_lvl_in = 1'b0;
               else if (phase == 5'd2)     scl_lvl_in = 1'b1;
               else                        sda_lvl_in = 1'b1;
            end
            i2cm_pkg::CMD_WRITE: begin
               priority if (phase < i2cm_pkg::WR_ACK_LOW_PHASE) begin
                  priority if (wr_rem == 5'd0) scl_lvl_in = 1'b0;
                  else if (wr_rem == 5'd1)     sda_lvl_in = shift_in[~wr_bit];
                  else                         scl_lvl_in = 1'b1;
               end else if (phase == i2cm_pkg::WR_ACK_LOW_PHASE) begin
                  sda_lvl_in = 1'b1;
                  scl_lvl_in = 1'b0;
               end else begin
                  scl_lvl_in = 1'b1;
                  ack_reg_in = req_word.sda_in;
               end
            end
            i2cm_pkg::CMD_READ: begin
               priority if (phase < i2cm_pkg::RD_ACK_LOW_PHASE) begin
                  if (!phase[0]) begin
                     if (phase == 5'd0) sda_lvl_in = 1'b1;
                     scl_lvl_in = 1'b0;
                  end else begin
                     scl_lvl_in = 1'b1;
                  end
               end else if (phase == i2cm_pkg::RD_ACK_LOW_PHASE) begin
                  scl_lvl_in = 1'b0;
               end else if (phase == i2cm_pkg::RD_ACK_SDA_PHASE) begin
                  sda_lvl_in = pend_in;
               end else begin
                  scl_lvl_in = 1'b1;
               end
            end
         endcase
      end
   end

   // A read phase that raises SCL shifts the sampled SDA in, MSB first.
   always_comb begin
      shift_out = shift_in;
      if (do_phase && cmd_in == i2cm_pkg::CMD_READ
          && phase < i2cm_pkg::RD_ACK_LOW_PHASE && phase[0]) begin
         shift_out = {shift_in[6:0], req_word.sda_in};
      end
   end

   always_comb begin
      rsp_word.scl_out      = scl_lvl_in;
      rsp_word.sda_out      = sda_lvl_in;
      rsp_word.busy_res     = (step_in != '0);
      rsp_word.done_res     = done;
      rsp_word.read_byte    = rdata_in;
      rsp_word.ack_received = ack_reg_in;
   end

endmodule

@@ rtl/core/i2cm_rsp_buf.sv @@
module i2cm_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  i2cm_pkg::rsp_word_type push_word,
   output logic                  push_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output i2cm_pkg::rsp_word_type out_word
);

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   i2cm_pkg::rsp_word_type main_ff, main_in;
   i2cm_pkg::rsp_word_type skid_ff, skid_in;
   logic                  pop;

   assign pop        = main_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_word   = main_ff;

   // A second word waits in the skid stage while the output one is stalled.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_word;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

@@ rtl/core/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer. Every req word is one timing tick: it may carry a
// start, stop, write-byte or read-byte command, which is taken only while the
// sequencer is idle, and each word yields exactly one rsp word with the SCL and
// SDA levels, busy and done flags, the last read byte and the last received
// acknowledge. A word is accepted in every cycle while the output buffer has room; the
// sequence state updates in one pass between the tick input and a result
// register, and a two-word output buffer lets req stay ready while one result
// waits, so req_bus.ready drops only when two results are stalled. Each phase
// lasts csr phase_ticks ticks (reset 4, zero acts as one); write csr only idle.
module i2c_master_bit_sequencer (
   input  logic          clock,
   input  logic          reset,
   i2cm_stream_if.sink   req_bus,
   i2cm_stream_if.source rsp_bus,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);

   logic                  accept;
   logic                  buf_ready;
   i2cm_pkg::req_word_type req_word;
   i2cm_pkg::rsp_word_type step_word;
   i2cm_pkg::rsp_word_type out_word;

   assign req_word      = req_bus.data;
   assign req_bus.ready = buf_ready;
   assign accept        = req_bus.valid && buf_ready;
   assign rsp_bus.data  = out_word;

   i2cm_seq_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_word    (step_word)
   );

   i2cm_rsp_buf u_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_word  (step_word),
      .push_ready (buf_ready),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_word   (out_word)
   );

endmodule

@@ rtl/core/i2cm_checker.sv @@
`include "i2c_master_bit_sequencer_assert.svh"

module i2cm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input i2cm_pkg::rsp_word_type rsp_data
);

   // Input backpressure only happens behind a waiting result.
   `I2CM_ASSERT_SAME(a_ready_low_needs_rsp, clock, reset, !req_ready, rsp_valid)

   // An accepted word into an empty output shows up on the next cycle.
   `I2CM_ASSERT_NEXT(a_word_reaches_rsp, clock, reset, req_valid && req_ready && !rsp_valid, rsp_valid)

   // The finishing tick is never reported as busy.
   `I2CM_ASSERT_SAME(a_done_not_busy, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res)

   `I2CM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data)
);

@@ dv/i2c_master_bit_sequencer_tb.sv @@
module i2c_master_bit_sequencer_tb;
   import i2cm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   i2cm_stream_if #(.payload_type(req_word_type)) req_if ();
   i2cm_stream_if #(.payload_type(rsp_word_type)) rsp_if ();

   i2c_master_bit_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bus sequencer state as the testbench predicts it.
   logic [15:0] m_phase_ticks = PHASE_TICKS_RESET;
   logic [15:0] m_ticks_left = 16'd0;
   logic [5:0]  m_step = 6'd0;
   logic [7:0]  m_shift = 8'd0;
   cmd_type     m_cmd = CMD_START;
   logic        m_scl = 1'b1;
   logic        m_sda = 1'b1;
   logic        m_ack_in = 1'b0;
   logic        m_ack_out = 1'b0;
   logic [7:0]  m_read_data = 8'd0;

   req_word_type tick_words[$];
   rsp_word_type predicted_status[$];
   int unsigned  words_queued = 0;
   int unsigned  words_accepted = 0;
   int unsigned  status_checked = 0;
   int unsigned  mismatch_count = 0;

   bit          gaps_on = 1'b1;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   logic        hold_rsp = 1'b0;

   function automatic logic [5:0] last_step(cmd_type c);
      case (c)
         CMD_WRITE: return WRITE_LAST_STEP;
         CMD_READ:  return READ_LAST_STEP;
         default:   return SHORT_LAST_STEP;
      endcase
   endfunction

   // Pin action of the phase that has just been entered.
   function automatic void enter_phase(logic sda_sample);
      int s;
      int b;
      s = int'(m_step) - 1;
      case (m_cmd)
         CMD_START: begin
            if (s == 0) m_scl = 1'b0;
            else if (s == 1) m_sda = 1'b1;
            else if (s == 2) m_scl = 1'b1;
            else m_sda = 1'b0;
         end
         CMD_STOP: begin
            if (s == 0) m_scl = 1'b0;
            else if (s == 1) m_sda = 1'b0;
            else if (s == 2) m_scl = 1'b1;
            else m_sda = 1'b1;
         end
         CMD_WRITE: begin
            if (s < int'(WR_ACK_LOW_PHASE)) begin
               b = s / 3;
               case (s % 3)
                  0:       m_scl = 1'b0;
                  1:       m_sda = m_shift[7 - b];
                  default: m_scl = 1'b1;
               endcase
            end else if (s == int'(WR_ACK_LOW_PHASE)) begin
               m_sda = 1'b1;
               m_scl = 1'b0;
            end else begin
               m_scl = 1'b1;
               m_ack_in = sda_sample;
            end
         end
         default: begin
            if (s < int'(RD_ACK_LOW_PHASE)) begin
               if (s % 2 == 0) begin
                  if (s == 0) m_sda = 1'b1;
                  m_scl = 1'b0;
               end else begin
                  m_scl = 1'b1;
                  m_shift = {m_shift[6:0], sda_sample};
               end
            end else if (s == int'(RD_ACK_LOW_PHASE)) begin
               m_scl = 1'b0;
            end else if (s == int'(RD_ACK_SDA_PHASE)) begin
               m_sda = m_ack_out;
            end else begin
               m_scl = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic rsp_word_type next_bus_status(req_word_type w);
      rsp_word_type r;
      logic [15:0]  hold;
      logic         done;
      hold = (m_phase_ticks == 16'd0) ? 16'd1 : m_phase_ticks;
      done = 1'b0;
      if (m_step == 6'd0) begin
         if (w.cmd_valid) begin
            m_cmd = w.command;
            if (w.command == CMD_WRITE) m_shift = w.write_byte;
            if (w.command == CMD_READ) begin
               m_shift = 8'd0;
               m_ack_out = w.ack_to_send;
            end
            m_step = 6'd1;
            enter_phase(w.sda_in);
            m_ticks_left = hold;
         end
      end else begin
         if (m_ticks_left != 16'd0) m_ticks_left = m_ticks_left - 16'd1;
         if (m_ticks_left == 16'd0) begin
            if (m_step >= last_step(m_cmd)) begin
               if (m_cmd == CMD_READ) m_read_data = m_shift;
               m_step = 6'd0;
               done = 1'b1;
            end else begin
               m_step = m_step + 6'd1;
               enter_phase(w.sda_in);
               m_ticks_left = hold;
            end
         end
      end
      r.scl_out = m_scl;
      r.sda_out = m_sda;
      r.busy_res = (m_step != 6'd0);
      r.done_res = done;
      r.read_byte = m_read_data;
      r.ack_received = m_ack_in;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < 30)
         $display("mismatch at %0t on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (tick_words.size() != 0) begin
            req_if.valid <= 1'b1;
            req_if.data <= tick_words.pop_front();
            send_gap <= pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      rsp_word_type got;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predicted_status.push_back(next_bus_status(req_if.data));
            words_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (predicted_status.size() == 0) begin
               report_mismatch("unexpected word", int'(got), 0);
            end else begin
               want = predicted_status.pop_front();
               if (got.scl_out !== want.scl_out)
                  report_mismatch("scl_out", got.scl_out, want.scl_out);
               if (got.sda_out !== want.sda_out)
                  report_mismatch("sda_out", got.sda_out, want.sda_out);
               if (got.busy_res !== want.busy_res)
                  report_mismatch("busy_res", got.busy_res, want.busy_res);
               if (got.done_res !== want.done_res)
                  report_mismatch("done_res", got.done_res, want.done_res);
               if (got.read_byte !== want.read_byte)
                  report_mismatch("read_byte", got.read_byte, want.read_byte);
               if (got.ack_received !== want.ack_received)
                  report_mismatch("ack_received", got.ack_received, want.ack_received);
            end
            status_checked++;
         end
      end
   end

   function automatic req_word_type random_tick(int unsigned offer_pct);
      req_word_type w;
      w.cmd_valid = ($urandom_range(0, 99) < offer_pct);
      w.command = cmd_type'($urandom_range(0, 3));
      w.write_byte = 8'($urandom);
      w.ack_to_send = 1'($urandom);
      w.sda_in = 1'($urandom);
      return w;
   endfunction

   task automatic push_tick(req_word_type w);
      tick_words.push_back(w);
      words_queued++;
   endtask

   // One command word followed by exactly as many ticks as the sequence lasts, so the
   // last of them is the done tick. sda_mode 0 or 1 holds sda_in, 2 leaves it random.
   task automatic push_command(cmd_type c, logic [7:0] data_byte, logic ack, int sda_mode,
                               int unsigned offer_pct);
      req_word_type w;
      int unsigned  n;
      w = random_tick(100);
      w.command = c;
      w.write_byte = data_byte;
      w.ack_to_send = ack;
      n = int'(last_step(c)) * ((m_phase_ticks == 16'd0) ? 1 : int'(m_phase_ticks));
      push_tick(w);
      repeat (n) begin
         w = random_tick(offer_pct);
         if (sda_mode < 2) w.sda_in = 1'(sda_mode);
         push_tick(w);
      end
   endtask

   task automatic drain();
      wait (status_checked >= words_queued);
      @(posedge clock);
   endtask

   // The phase length may only change while no sequence is running.
   task automatic set_phase_ticks(logic [15:0] value);
      drain();
      while (m_step != 6'd0) begin
         repeat (64) push_tick(random_tick(0));
         drain();
      end
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      m_phase_ticks = value;
   endtask

   initial begin
      logic [15:0]  ticks_plan [6];
      req_word_type w;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset phase length.
      push_command(CMD_START, 8'h00, 1'b0, 2, 0);
      set_phase_ticks(16'd1);
      push_command(CMD_STOP, 8'h00, 1'b0, 2, 100);
      push_command(CMD_WRITE, 8'hFF, 1'b1, 1, 0);
      push_command(CMD_WRITE, 8'h00, 1'b0, 0, 50);
      push_command(CMD_READ, 8'h00, 1'b0, 1, 0);
      push_command(CMD_READ, 8'hFF, 1'b1, 0, 0);
      push_command(CMD_WRITE, 8'hA5, 1'b0, 2, 0);
      repeat (3) push_tick(random_tick(0));
      set_phase_ticks(16'd0);
      push_command(CMD_START, 8'h00, 1'b0, 2, 0);
      push_command(CMD_READ, 8'h5A, 1'b1, 2, 0);

      // Random ticks under several phase lengths; one stretch runs without gaps.
      ticks_plan = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd5, 16'd1};
      ticks_plan[5] = 16'($urandom_range(1, 9));
      for (int i = 0; i < 6; i++) begin
         set_phase_ticks(ticks_plan[i]);
         gaps_on = (i != 2);
         repeat (180) push_tick(random_tick(75));
      end

      // A phase longer than an 8-bit count: a stop is started and followed
      // past its first phase boundary.
      set_phase_ticks(16'd300);
      gaps_on = 1'b1;
      w = random_tick(100);
      w.command = CMD_STOP;
      push_tick(w);
      repeat (320) push_tick(random_tick(50));

      drain();
      repeat (20) @(posedge clock);
      if (predicted_status.size() != 0)
         report_mismatch("words never returned", 0, predicted_status.size());
      if (mismatch_count == 0)
         $display("i2c_master_bit_sequencer regression: pass");
      else
         $display("i2c_master_bit_sequencer regression: fail");
      $finish;
   end

   // Long result stall while words keep coming, so the output buffer fills up.
   initial begin
      wait (words_accepted >= 600);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (80) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #20000000;
      $display("i2c_master_bit_sequencer regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_stream_if.sv
rtl/core/i2cm_seq_core.sv
rtl/core/i2cm_rsp_buf.sv
rtl/core/i2c_master_bit_sequencer.sv
rtl/core/i2cm_checker.sv
dv/i2c_master_bit_sequencer_tb.sv
